>>> rtl/lzdlc_pkg.sv
// shared types and constants for the lzss decoded length counter
package lzdlc_pkg;

  localparam int LEN_BITS        = 29;
  localparam int COUNT_BITS_DEF  = 29;
  localparam int BYTE_BITS       = 8;
  localparam int FLAG_BITS       = 16;
  localparam int ADD_BITS        = 5;
  localparam int DATA_BITS       = 32;
  localparam int ADDR_BITS       = 3;

  localparam logic [LEN_BITS-1:0]  MAX_RESET  = LEN_BITS'(32'h1000_0000);
  localparam logic [BYTE_BITS-1:0] FLAG_FILL  = 8'hFF;
  localparam logic [ADD_BITS-1:0]  LIT_ADD    = 5'd1;
  localparam logic [ADD_BITS-1:0]  MATCH_BASE = 5'd3;

  // register index taken from paddr[2]
  localparam logic REG_MAX_LEN = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_AFTER_FLAG = 2'd1,
    PH_MATCH_HI   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

endpackage

>>> rtl/lzdlc_in_if.sv
// input channel: one compressed payload byte per word
interface lzdlc_in_if;
  logic                             valid;
  logic                             ready;
  logic [lzdlc_pkg::BYTE_BITS-1:0]  data_byte;
  logic                             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/lzdlc_out_if.sv
// output channel: decoded length and status per payload
interface lzdlc_out_if;
  logic                            valid;
  logic                            ready;
  logic [lzdlc_pkg::LEN_BITS-1:0]  decoded_length;
  logic [1:0]                      status;

  modport source (output valid, output decoded_length, output status, input ready);
  modport sink   (input valid, input decoded_length, input status, output ready);
endinterface

>>> rtl/lzdlc_top.sv
// Top level of the LZSS decoded length counter. Each input word is one
// compressed payload byte; the block walks the flag/literal/match tokens
// and counts the bytes the stream would decode to. A byte marked last
// yields one output word with the length and a status (ok, empty, too
// long); other bytes yield nothing. One byte is taken per clock: the byte
// is registered, the token step and count add are combinational into the
// walk state, and the result sits in an output register so the next
// payload keeps flowing while it waits. The result word passes from the
// input register to the output register; a last byte stalls the input only while
// the previous result is still unread. The length limit is written
// through the APB port at address 0.
module lzss_decoded_length_counter_top #(
  parameter int COUNT_BITS = lzdlc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  lzdlc_in_if.sink                         tokens,
  lzdlc_out_if.source                      lengths,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lzdlc_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lzdlc_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lzdlc_pkg::DATA_BITS-1:0]  prdata,
  output logic                             pready
);

  logic [lzdlc_pkg::LEN_BITS-1:0] max_len;

  lzdlc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  lzdlc_walk #(
    .COUNT_BITS (COUNT_BITS)
  ) u_walk (
    .clk     (clk),
    .rst     (rst),
    .max_len (max_len),
    .tokens  (tokens),
    .lengths (lengths)
  );

endmodule

>>> rtl/lzdlc_cfg.sv
// apb register file holding the maximum decoded length
module lzdlc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lzdlc_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [lzdlc_pkg::DATA_BITS-1:0]     pwdata,
  output logic [lzdlc_pkg::DATA_BITS-1:0]     prdata,
  output logic                                pready,
  output logic [lzdlc_pkg::LEN_BITS-1:0]      max_len
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lzdlc_pkg::MAX_RESET;
    end else if (wr_en && paddr[2] == lzdlc_pkg::REG_MAX_LEN) begin
      max_len <= pwdata[lzdlc_pkg::LEN_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lzdlc_pkg::REG_MAX_LEN) begin
      prdata = lzdlc_pkg::DATA_BITS'(max_len);
    end
  end

endmodule

>>> rtl/lzdlc_walk.sv
// input register, token walk with running count, and result register
module lzdlc_walk #(
  parameter int COUNT_BITS = lzdlc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lzdlc_pkg::LEN_BITS-1:0]  max_len,
  lzdlc_in_if.sink                        tokens,
  lzdlc_out_if.source                     lengths
);

  localparam int W = ((COUNT_BITS > lzdlc_pkg::LEN_BITS) ? COUNT_BITS
                                                         : lzdlc_pkg::LEN_BITS) + 1;
  localparam logic [W-1:0] CNT_MASK = W'((65'd1 << COUNT_BITS) - 65'd1);

  // input stage
  logic                              in_full;
  logic [lzdlc_pkg::BYTE_BITS-1:0]   in_byte;
  logic                              in_last;

  // walk state
  lzdlc_pkg::phase_t                 phase, phase_next;
  logic [lzdlc_pkg::FLAG_BITS-1:0]   flags, flags_next;
  logic [COUNT_BITS-1:0]             count;
  logic                              ovf;

  // result stage
  logic                              res_full;
  logic [lzdlc_pkg::LEN_BITS-1:0]    res_len, res_len_next;
  lzdlc_pkg::status_t                res_status, res_status_next;

  logic                              can_go;
  logic                              add_en;
  logic [lzdlc_pkg::ADD_BITS-1:0]    add_n;
  logic [lzdlc_pkg::FLAG_BITS-1:0]   shifted;
  logic [W-1:0]                      limit;
  logic [W-1:0]                      max_ext;
  logic [W-1:0]                      sum;
  logic [COUNT_BITS-1:0]             count_upd;
  logic                              ovf_upd;

  assign can_go         = in_full && (!in_last || !res_full || lengths.ready);
  assign tokens.ready   = !in_full || can_go;
  assign lengths.valid  = res_full;
  assign lengths.decoded_length = res_len;
  assign lengths.status = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (tokens.ready) begin
      in_full <= tokens.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tokens.ready && tokens.valid) begin
      in_byte <= tokens.data_byte;
      in_last <= tokens.last_byte;
    end
  end

  assign max_ext = W'(max_len);
  assign limit   = (max_ext < CNT_MASK) ? max_ext : CNT_MASK;
  assign shifted = flags >> 1;

  // token decode
  always_comb begin
    phase_next = lzdlc_pkg::PH_IDLE;
    flags_next = flags;
    add_en     = 1'b0;
    add_n      = lzdlc_pkg::LIT_ADD;
    unique case (phase)
      lzdlc_pkg::PH_AFTER_FLAG: begin
        if (flags[0]) begin
          add_en = 1'b1;
        end else begin
          phase_next = lzdlc_pkg::PH_MATCH_HI;
        end
      end
      lzdlc_pkg::PH_MATCH_HI: begin
        add_en = 1'b1;
        add_n  = lzdlc_pkg::ADD_BITS'(in_byte[3:0]) + lzdlc_pkg::MATCH_BASE;
      end
      default: begin
        flags_next = shifted;
        if (!shifted[8]) begin
          flags_next = {lzdlc_pkg::FLAG_FILL, in_byte};
          phase_next = lzdlc_pkg::PH_AFTER_FLAG;
        end else if (shifted[0]) begin
          add_en = 1'b1;
        end else begin
          phase_next = lzdlc_pkg::PH_MATCH_HI;
        end
      end
    endcase
  end

  // count update with limit check
  always_comb begin
    sum       = W'(count) + W'(add_n);
    count_upd = count;
    ovf_upd   = ovf;
    if (add_en && !ovf) begin
      if (sum > limit) begin
        ovf_upd = 1'b1;
      end else begin
        count_upd = COUNT_BITS'(sum);
      end
    end
  end

  always_comb begin
    res_len_next    = '0;
    res_status_next = lzdlc_pkg::ST_OK;
    if (ovf_upd) begin
      res_status_next = lzdlc_pkg::ST_TOO_LONG;
    end else if (count_upd == '0) begin
      res_status_next = lzdlc_pkg::ST_EMPTY;
    end else begin
      res_len_next = lzdlc_pkg::LEN_BITS'(count_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lzdlc_pkg::PH_IDLE;
      flags <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (can_go) begin
      if (in_last) begin
        phase <= lzdlc_pkg::PH_IDLE;
        flags <= '0;
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        phase <= phase_next;
        flags <= flags_next;
        count <= count_upd;
        ovf   <= ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (can_go && in_last) begin
      res_full <= 1'b1;
    end else if (lengths.ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_go && in_last) begin
      res_len    <= res_len_next;
      res_status <= res_status_next;
    end
  end

  a_err_zero_len: assert property (@(posedge clk) disable iff (rst)
    res_full && res_status != lzdlc_pkg::ST_OK |-> res_len == '0)
    else $error("error result carries nonzero length");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    can_go && in_last |=> count == '0 && !ovf && phase == lzdlc_pkg::PH_IDLE)
    else $error("walk state not cleared after last byte");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf && !(can_go && in_last) |=> ovf)
    else $error("overflow flag dropped before last byte");

  a_no_result_loss: assert property (@(posedge clk) disable iff (rst)
    res_full && !lengths.ready |=> res_full && $stable(res_len))
    else $error("pending result lost");

endmodule

>>> test/tb_lzss_decoded_length_counter_top.sv
// testbench for the lzss decoded length counter: directed table, then random token streams
module tb_lzss_decoded_length_counter_top;
  import lzdlc_pkg::*;

  localparam int COUNT_W = COUNT_BITS_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 170;
  localparam int N_PHASES = 6;
  localparam int N_ROWS = 28;
  localparam logic [ADDR_BITS-1:0] MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};

  typedef logic [LEN_BITS-1:0] len_t;

  typedef struct packed {
    len_t    len;
    status_t st;
  } length_word_t;

  typedef struct packed {
    logic                 is_cfg;
    len_t                 cfg_val;
    logic [BYTE_BITS-1:0] data;
    logic                 last;
    logic                 typed;
    len_t                 len;
    status_t              st;
  } row_t;

  localparam row_t DIRECTED [N_ROWS] = '{
    '{1'b0, '0, 8'h00, 1'b1, 1'b1, 29'd0,  ST_EMPTY},
    '{1'b0, '0, 8'hFF, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'hAB, 1'b1, 1'b1, 29'd1,  ST_OK},
    '{1'b0, '0, 8'h00, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h12, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'hFF, 1'b1, 1'b1, 29'd18, ST_OK},
    '{1'b0, '0, 8'hFE, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h34, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'hF0, 1'b1, 1'b1, 29'd3,  ST_OK},
    '{1'b0, '0, 8'h00, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h55, 1'b1, 1'b1, 29'd0,  ST_EMPTY},
    '{1'b0, '0, 8'hFF, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h01, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h02, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h04, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h08, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h10, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h20, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h40, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h80, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h00, 1'b1, 1'b0, '0,     ST_OK},
    '{1'b1, 29'd0, 8'h00, 1'b0, 1'b0, '0,  ST_OK},
    '{1'b0, '0, 8'hFF, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h00, 1'b1, 1'b1, 29'd0,  ST_TOO_LONG},
    '{1'b1, 29'd1, 8'h00, 1'b0, 1'b0, '0,  ST_OK},
    '{1'b0, '0, 8'hFF, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'h7F, 1'b0, 1'b0, '0,     ST_OK},
    '{1'b0, '0, 8'hFE, 1'b1, 1'b1, 29'd0,  ST_TOO_LONG}
  };

  localparam len_t PHASE_MAX [N_PHASES] = '{
    MAX_RESET, 29'd60, 29'd1, 29'd300, MAX_RESET, 29'd25
  };

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  lzdlc_in_if  tokens_if ();
  lzdlc_out_if lengths_if ();

  lzss_decoded_length_counter_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .tokens  (tokens_if),
    .lengths (lengths_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // walk state of the predictor
  phase_t               walk_phase;
  logic [FLAG_BITS-1:0] flag_bits;
  logic [COUNT_W-1:0]   run_count;
  logic                 limit_hit;
  len_t                 max_len;

  length_word_t         pending_lengths[$];
  logic [BYTE_BITS-1:0] payload[$];
  int                   mismatches = 0;
  int                   src_idle_pct = 0;
  int                   rcv_idle_pct = 0;
  int                   cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_walk();
    walk_phase = PH_IDLE;
    flag_bits  = '0;
    run_count  = '0;
    limit_hit  = 1'b0;
  endtask

  function automatic void add_to_count(input int unsigned n);
    logic [63:0] lim;
    logic [63:0] sum;
    lim = 64'(max_len);
    if (lim > ((64'd1 << COUNT_W) - 1)) lim = (64'd1 << COUNT_W) - 1;
    sum = 64'(run_count) + 64'(n);
    if (!limit_hit) begin
      if (sum > lim) limit_hit = 1'b1;
      else run_count = sum[COUNT_W-1:0];
    end
  endfunction

  task automatic walk_byte(input logic [BYTE_BITS-1:0] b, input logic l,
                           output logic has_res, output length_word_t res);
    case (walk_phase)
      PH_AFTER_FLAG: begin
        if (flag_bits[0]) begin
          add_to_count(LIT_ADD);
          walk_phase = PH_IDLE;
        end else begin
          walk_phase = PH_MATCH_HI;
        end
      end
      PH_MATCH_HI: begin
        add_to_count(b[3:0] + MATCH_BASE);
        walk_phase = PH_IDLE;
      end
      default: begin
        flag_bits = flag_bits >> 1;
        if (!flag_bits[8]) begin
          flag_bits  = {FLAG_FILL, b};
          walk_phase = PH_AFTER_FLAG;
        end else if (flag_bits[0]) begin
          add_to_count(LIT_ADD);
          walk_phase = PH_IDLE;
        end else begin
          walk_phase = PH_MATCH_HI;
        end
      end
    endcase
    has_res = l;
    if (limit_hit) res = '{len: '0, st: ST_TOO_LONG};
    else if (run_count == '0) res = '{len: '0, st: ST_EMPTY};
    else res = '{len: LEN_BITS'(run_count), st: ST_OK};
    if (l) clear_walk();
  endtask

  task automatic put_word(input logic [BYTE_BITS-1:0] b, input logic l, input logic typed,
                          input length_word_t typed_res);
    logic         has_res;
    length_word_t res;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      tokens_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    tokens_if.valid     <= 1'b1;
    tokens_if.data_byte <= b;
    tokens_if.last_byte <= l;
    @(posedge clk);
    while (!tokens_if.ready) @(posedge clk);
    walk_byte(b, l, has_res, res);
    if (has_res) pending_lengths.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    tokens_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_lengths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input len_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= DATA_BITS'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_len = v;
  endtask

  // mostly well-formed flag groups, some cut short, some plain noise
  task automatic make_payload();
    int                   kind;
    int                   ntok;
    logic [BYTE_BITS-1:0] flags;
    payload.delete();
    flags = '0;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 24)) payload.push_back(8'($urandom));
    end else begin
      ntok = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
      for (int t = 0; t < ntok; t++) begin
        if (t % 8 == 0) begin
          flags = 8'($urandom);
          payload.push_back(flags);
        end
        payload.push_back(8'($urandom));
        if (!flags[t % 8]) payload.push_back(8'($urandom));
      end
      if (kind < 28) void'(payload.pop_back());
    end
  endtask

  always @(posedge clk) begin
    if (rst) lengths_if.ready <= 1'b0;
    else lengths_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin : check_lengths
    length_word_t want;
    if (!rst && lengths_if.valid && lengths_if.ready) begin
      if (pending_lengths.size() == 0) begin
        report_mismatch($sformatf("unexpected word len %0d status %0d",
                                  lengths_if.decoded_length, lengths_if.status));
      end else begin
        want = pending_lengths.pop_front();
        if (lengths_if.decoded_length !== want.len)
          report_mismatch($sformatf("decoded_length %0d, want %0d",
                                    lengths_if.decoded_length, want.len));
        if (lengths_if.status !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", lengths_if.status, want.st));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int           words;
    int           n_payloads;
    length_word_t no_res;
    rst                 <= 1'b1;
    tokens_if.valid     <= 1'b0;
    tokens_if.data_byte <= '0;
    tokens_if.last_byte <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    no_res = '{len: '0, st: ST_OK};
    n_payloads = 0;
    max_len = MAX_RESET;
    clear_walk();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 7;
    rcv_idle_pct = 64;
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].is_cfg) begin
        drain_results();
        write_max_len(DIRECTED[r].cfg_val);
      end else begin
        put_word(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed,
                 '{len: DIRECTED[r].len, st: DIRECTED[r].st});
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      write_max_len(PHASE_MAX[ph]);
      case (ph / 2)
        0: begin
          src_idle_pct = 7;
          rcv_idle_pct = 64;
        end
        1: begin
          src_idle_pct = 64;
          rcv_idle_pct = 7;
        end
        default: begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      words = 0;
      while (words < PHASE_WORDS) begin
        if (n_payloads % 17 == 16) drain_results();
        make_payload();
        foreach (payload[i]) put_word(payload[i], i == payload.size() - 1, 1'b0, no_res);
        words += payload.size();
        n_payloads++;
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
